[hw/rtl/assert_macros.svh]
// Assertion macros used by the RTL top level of the film drive interlock.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every rising clock edge outside reset.
`define FDCI_ASSERT(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that a trigger is followed by a consequence in the next cycle.
`define FDCI_ASSERT_NEXT(lbl, clk, rst_n, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/fdci_pkg.sv]
// Types, bit positions and helpers for the film drive clutch interlock.
package fdci_pkg;

    // Bit positions in the inverted button byte.
    localparam int unsigned BTN_FW1    = 7;
    localparam int unsigned BTN_REV1   = 6;
    localparam int unsigned BTN_FW2    = 5;
    localparam int unsigned BTN_REV2   = 4;
    localparam int unsigned BTN_FW3    = 3;
    localparam int unsigned BTN_REV3   = 2;
    localparam int unsigned BTN_FWALL  = 1;
    localparam int unsigned BTN_REVALL = 0;

    // Bit positions in the clutch force word.
    localparam int unsigned CL_BLK1 = 0;
    localparam int unsigned CL_BLK2 = 1;
    localparam int unsigned CL_BLK3 = 2;
    localparam int unsigned CL_MAIN = 3;

    localparam int unsigned BTN_W    = 8;
    localparam int unsigned FB_W     = 3;
    localparam int unsigned CLUTCH_W = 4;
    localparam int unsigned MODE_W   = 2;

    // Reported mode codes.
    localparam logic [MODE_W-1:0] CODE_IDLE    = 2'd0;
    localparam logic [MODE_W-1:0] CODE_PREPARE = 2'd1;
    localparam logic [MODE_W-1:0] CODE_MOVING  = 2'd2;
    localparam logic [MODE_W-1:0] CODE_HALT    = 2'd3;

    typedef enum logic [3:0] {
        MODE_IDLE    = 4'b0001,
        MODE_PREPARE = 4'b0010,
        MODE_MOVING  = 4'b0100,
        MODE_HALT    = 4'b1000
    } mode_t;

    typedef struct packed {
        mode_t                 mode;
        logic [CLUTCH_W-1:0]   clutch;
        logic                  reverse;
        logic                  enable;
    } state_t;

    function automatic logic [MODE_W-1:0] mode_code(input mode_t m);
        logic [MODE_W-1:0] code;
        unique case (m)
            MODE_IDLE:    code = CODE_IDLE;
            MODE_PREPARE: code = CODE_PREPARE;
            MODE_MOVING:  code = CODE_MOVING;
            MODE_HALT:    code = CODE_HALT;
            default:      code = CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

[hw/rtl/fdci_step.sv]
// Button decode and next-state logic for one poll tick of the interlock.
module fdci_step (
    input  fdci_pkg::state_t                  cur,
    input  logic [fdci_pkg::BTN_W-1:0]        buttons_n,
    input  logic [fdci_pkg::FB_W-1:0]         feedback,
    input  logic                              inhibit,
    input  logic                              kill_ok,
    output fdci_pkg::state_t                  nxt
);

    logic [fdci_pkg::BTN_W-1:0] cmd;
    logic                       all_blk;
    logic                       m1;
    logic                       m2;
    logic                       m3;
    logic                       fw;
    logic                       rev;
    logic                       fb_match;

    assign cmd     = ~buttons_n;
    assign all_blk = cmd[fdci_pkg::BTN_FWALL] | cmd[fdci_pkg::BTN_REVALL];
    assign m1      = all_blk | cmd[fdci_pkg::BTN_FW1] | cmd[fdci_pkg::BTN_REV1];
    assign m2      = all_blk | cmd[fdci_pkg::BTN_FW2] | cmd[fdci_pkg::BTN_REV2];
    assign m3      = all_blk | cmd[fdci_pkg::BTN_FW3] | cmd[fdci_pkg::BTN_REV3];
    assign fw      = cmd[fdci_pkg::BTN_FW1] | cmd[fdci_pkg::BTN_FW2]
                   | cmd[fdci_pkg::BTN_FW3] | cmd[fdci_pkg::BTN_FWALL];
    assign rev     = cmd[fdci_pkg::BTN_REV1] | cmd[fdci_pkg::BTN_REV2]
                   | cmd[fdci_pkg::BTN_REV3] | cmd[fdci_pkg::BTN_REVALL];
    assign fb_match = (feedback[0] == m1) && (feedback[1] == m2) && (feedback[2] == m3);

    always_comb
    begin
        nxt = cur;
        if (!kill_ok)
        begin
            nxt.clutch  = '0;
            nxt.reverse = 1'b0;
            nxt.enable  = 1'b0;
            nxt.mode    = fdci_pkg::MODE_HALT;
        end
        else
        begin
            unique case (cur.mode)
                fdci_pkg::MODE_IDLE:
                begin
                    // Only a request in a single direction starts preparation.
                    if (fw ^ rev)
                    begin
                        nxt.clutch[fdci_pkg::CL_MAIN] = 1'b1;
                        nxt.clutch[fdci_pkg::CL_BLK1] = ~m1;
                        nxt.clutch[fdci_pkg::CL_BLK2] = ~m2;
                        nxt.clutch[fdci_pkg::CL_BLK3] = ~m3;
                        nxt.reverse = rev;
                        nxt.mode    = fdci_pkg::MODE_PREPARE;
                    end
                end
                fdci_pkg::MODE_PREPARE:
                begin
                    if (cmd == '0)
                    begin
                        nxt.reverse = 1'b0;
                        nxt.clutch  = '0;
                        nxt.mode    = fdci_pkg::MODE_IDLE;
                    end
                    else if (!inhibit && fb_match)
                    begin
                        nxt.enable = 1'b1;
                        nxt.mode   = fdci_pkg::MODE_MOVING;
                    end
                end
                fdci_pkg::MODE_MOVING:
                begin
                    // Release, or a reverse request while moving forward, drops back to preparing; clutches stay.
                    if ((cmd == '0) || (!cur.reverse && rev))
                    begin
                        nxt.reverse = 1'b0;
                        nxt.enable  = 1'b0;
                        nxt.mode    = fdci_pkg::MODE_PREPARE;
                    end
                end
                default:
                begin
                    nxt.clutch  = '0;
                    nxt.reverse = 1'b0;
                    nxt.enable  = 1'b0;
                    nxt.mode    = fdci_pkg::MODE_IDLE;
                end
            endcase
        end
    end

endmodule

[hw/rtl/film_drive_clutch_interlock.sv]
// Top level of the film drive clutch interlock: input stage, state and result register.
//
// Use: each input word is one poll tick carrying the active-low move buttons,
// the three clutch feedback switches, the start inhibit and the kill switch
// line. Both channels are valid/ready; a word moves when valid and ready are
// high at a rising clock edge. Every input word yields exactly one output
// word: the clutch force pattern, the reverse and motor relay drives and the
// mode code, all as they stand after that tick.
// A word accepted into the input register is decoded, and the state update
// loads the result into the state register, where out_valid rises. The state
// register is also the result register. Throughput is one word per cycle
// while the receiver does not stall.
// When the receiver stalls, the result and the state hold, the input
// register keeps one more word and then in_ready drops; no word is lost.
// Reset (rst_n low) empties both stages and puts the block in idle with all
// relay and clutch outputs cleared.
`include "assert_macros.svh"

module film_drive_clutch_interlock (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [fdci_pkg::BTN_W-1:0]          move_buttons_n,
    input  logic [fdci_pkg::FB_W-1:0]           feedback_switches,
    input  logic                                start_inhibit,
    input  logic                                kill_released,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [fdci_pkg::CLUTCH_W-1:0]       clutch_force,
    output logic                                motor_reverse,
    output logic                                motor_enable,
    output logic [fdci_pkg::MODE_W-1:0]         mode_now
);

    logic                         stage_valid_reg;
    logic [fdci_pkg::BTN_W-1:0]   buttons_reg;
    logic [fdci_pkg::FB_W-1:0]    feedback_reg;
    logic                         inhibit_reg;
    logic                         kill_ok_reg;
    logic                         out_valid_reg;
    fdci_pkg::state_t             state_reg;
    fdci_pkg::state_t             state_next;
    logic                         out_free;
    logic                         advance;
    logic                         in_take;

    assign out_free = !out_valid_reg || out_ready;
    assign advance  = stage_valid_reg && out_free;
    assign in_ready = !stage_valid_reg || out_free;
    assign in_take  = in_valid && in_ready;

    fdci_step u_step (
        .cur       (state_reg),
        .buttons_n (buttons_reg),
        .feedback  (feedback_reg),
        .inhibit   (inhibit_reg),
        .kill_ok   (kill_ok_reg),
        .nxt       (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            stage_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            buttons_reg  <= move_buttons_n;
            feedback_reg <= feedback_switches;
            inhibit_reg  <= start_inhibit;
            kill_ok_reg  <= kill_released;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg     <= 1'b0;
            state_reg.mode    <= fdci_pkg::MODE_IDLE;
            state_reg.clutch  <= '0;
            state_reg.reverse <= 1'b0;
            state_reg.enable  <= 1'b0;
        end
        else
        begin
            if (out_free)
            begin
                out_valid_reg <= stage_valid_reg;
            end
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign clutch_force  = state_reg.clutch;
    assign motor_reverse = state_reg.reverse;
    assign motor_enable  = state_reg.enable;
    assign mode_now      = fdci_pkg::mode_code(state_reg.mode);

    `FDCI_ASSERT(a_enable_only_moving, clk, rst_n,
        !state_reg.enable || (state_reg.mode == fdci_pkg::MODE_MOVING),
        "motor enabled outside the moving mode")
    `FDCI_ASSERT(a_halt_outputs_clear, clk, rst_n,
        (state_reg.mode != fdci_pkg::MODE_HALT)
        || ((state_reg.clutch == '0) && !state_reg.reverse && !state_reg.enable),
        "outputs not cleared in the halt")
    `FDCI_ASSERT(a_reverse_mode, clk, rst_n,
        !state_reg.reverse || (state_reg.mode == fdci_pkg::MODE_PREPARE)
        || (state_reg.mode == fdci_pkg::MODE_MOVING),
        "reverse relay driven while idle or halted")
    `FDCI_ASSERT_NEXT(a_advance_gives_word, clk, rst_n, advance, out_valid_reg,
        "state update without an output word")
    `FDCI_ASSERT_NEXT(a_stall_holds_state, clk, rst_n,
        out_valid_reg && !out_ready, $stable(state_reg),
        "state changed while the output word was stalled")

endmodule

[tb/film_drive_clutch_interlock_test.sv]
// Self-checking testbench for the film drive clutch interlock.
module film_drive_clutch_interlock_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_TICKS = 1300;
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned DRAIN_EVERY  = 320;
    localparam int unsigned SHOWN_ERRORS = 10;

    localparam logic [fdci_pkg::BTN_W-1:0] NO_BUTTONS = '1;
    localparam logic [fdci_pkg::BTN_W-1:0] FW_LANES   =
        8'((1 << fdci_pkg::BTN_FW1) | (1 << fdci_pkg::BTN_FW2)
           | (1 << fdci_pkg::BTN_FW3) | (1 << fdci_pkg::BTN_FWALL));
    localparam logic [fdci_pkg::BTN_W-1:0] REV_LANES  =
        8'((1 << fdci_pkg::BTN_REV1) | (1 << fdci_pkg::BTN_REV2)
           | (1 << fdci_pkg::BTN_REV3) | (1 << fdci_pkg::BTN_REVALL));

    typedef struct packed {
        logic [fdci_pkg::CLUTCH_W-1:0] clutch;
        logic                          reverse;
        logic                          enable;
        logic [fdci_pkg::MODE_W-1:0]   mode;
    } tick_result_t;

    typedef struct packed {
        logic       fw;
        logic       rev;
        logic [2:0] moves;    // bit i: block i+1 is asked to move
    } request_t;

    typedef struct packed {
        logic [fdci_pkg::BTN_W-1:0] buttons_n;
        logic [fdci_pkg::FB_W-1:0]  feedback;
        logic                       inhibit;
        logic                       kill_ok;
        logic                       typed;
        tick_result_t               want;
    } tick_row_t;

    localparam logic TYPED     = 1'b1;
    localparam logic PREDICTED = 1'b0;

    localparam tick_result_t AT_IDLE = '{clutch: '0, reverse: 1'b0, enable: 1'b0,
                                         mode: fdci_pkg::CODE_IDLE};
    localparam tick_result_t AT_HALT = '{clutch: '0, reverse: 1'b0, enable: 1'b0,
                                         mode: fdci_pkg::CODE_HALT};

    // Rows marked TYPED carry their own result; the rest go through the predictor.
    localparam int unsigned SCRIPT_LEN = 25;
    localparam tick_row_t SCRIPT [SCRIPT_LEN] = '{
        '{8'hFF, 3'd0, 1'b0, 1'b1, TYPED,     AT_IDLE},  // nothing pressed
        '{8'h00, 3'd7, 1'b0, 1'b1, TYPED,     AT_IDLE},  // forward and reverse together
        '{8'hFF, 3'd7, 1'b1, 1'b0, TYPED,     AT_HALT},  // kill from idle
        '{8'h7F, 3'd1, 1'b0, 1'b1, TYPED,     AT_IDLE},  // kill released, buttons ignored
        '{8'h7F, 3'd0, 1'b0, 1'b1, PREDICTED, AT_IDLE},  // forward block 1
        '{8'h7F, 3'd0, 1'b0, 1'b1, PREDICTED, AT_IDLE},  // feedback disagrees
        '{8'h7F, 3'd1, 1'b1, 1'b1, PREDICTED, AT_IDLE},  // start inhibited
        '{8'h7F, 3'd1, 1'b0, 1'b1, PREDICTED, AT_IDLE},  // motor starts
        '{8'h7F, 3'd1, 1'b0, 1'b1, PREDICTED, AT_IDLE},
        '{8'hBF, 3'd1, 1'b0, 1'b1, PREDICTED, AT_IDLE},  // reversal stop
        '{8'hBF, 3'd1, 1'b0, 1'b1, PREDICTED, AT_IDLE},  // restart with the relay off
        '{8'hFF, 3'd1, 1'b0, 1'b1, PREDICTED, AT_IDLE},  // release while moving
        '{8'hFF, 3'd1, 1'b0, 1'b1, PREDICTED, AT_IDLE},  // release while preparing
        '{8'hFE, 3'd0, 1'b0, 1'b1, PREDICTED, AT_IDLE},  // reverse all
        '{8'hFE, 3'd7, 1'b0, 1'b1, PREDICTED, AT_IDLE},
        '{8'hFC, 3'd7, 1'b0, 1'b1, PREDICTED, AT_IDLE},  // both directions, relay already on
        '{8'hFC, 3'd7, 1'b0, 1'b0, TYPED,     AT_HALT},  // kill while moving
        '{8'h00, 3'd0, 1'b1, 1'b0, TYPED,     AT_HALT},  // kill held
        '{8'hFF, 3'd0, 1'b0, 1'b1, TYPED,     AT_IDLE},
        '{8'hEF, 3'd0, 1'b0, 1'b1, PREDICTED, AT_IDLE},  // reverse block 2
        '{8'hEF, 3'd2, 1'b0, 1'b1, PREDICTED, AT_IDLE},
        '{8'hEF, 3'd2, 1'b0, 1'b0, TYPED,     AT_HALT},
        '{8'hFF, 3'd5, 1'b1, 1'b1, TYPED,     AT_IDLE},
        '{8'hF7, 3'd3, 1'b0, 1'b1, PREDICTED, AT_IDLE},  // forward block 3
        '{8'hF7, 3'd4, 1'b0, 1'b1, PREDICTED, AT_IDLE}
    };

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    logic [fdci_pkg::BTN_W-1:0]    move_buttons_n;
    logic [fdci_pkg::FB_W-1:0]     feedback_switches;
    logic                          start_inhibit;
    logic                          kill_released;
    logic                          out_valid;
    logic                          out_ready;
    logic [fdci_pkg::CLUTCH_W-1:0] clutch_force;
    logic                          motor_reverse;
    logic                          motor_enable;
    logic [fdci_pkg::MODE_W-1:0]   mode_now;

    // Travels with each word so the monitor knows whether a typed result applies.
    logic         row_typed;
    tick_result_t row_want;

    logic [fdci_pkg::MODE_W-1:0]   pred_mode    = fdci_pkg::CODE_IDLE;
    logic [fdci_pkg::CLUTCH_W-1:0] pred_clutch  = '0;
    logic                          pred_reverse = 1'b0;
    logic                          pred_enable  = 1'b0;

    tick_result_t pending [$];
    tick_result_t seen_word;
    tick_result_t next_word;
    int unsigned  mismatches = 0;
    int unsigned  sent = 0;
    int unsigned  cycles = 0;
    bit           calm = 1'b0;

    film_drive_clutch_interlock u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .move_buttons_n    (move_buttons_n),
        .feedback_switches (feedback_switches),
        .start_inhibit     (start_inhibit),
        .kill_released     (kill_released),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .clutch_force      (clutch_force),
        .motor_reverse     (motor_reverse),
        .motor_enable      (motor_enable),
        .mode_now          (mode_now)
    );

    always #10 clk = ~clk;

    function automatic request_t decode_request(input logic [fdci_pkg::BTN_W-1:0] buttons_n);
        logic [fdci_pkg::BTN_W-1:0] pressed;
        logic                       all_blocks;
        request_t                   req;
        pressed = ~buttons_n;
        all_blocks = pressed[fdci_pkg::BTN_FWALL] | pressed[fdci_pkg::BTN_REVALL];
        req.moves[fdci_pkg::CL_BLK1] = all_blocks | pressed[fdci_pkg::BTN_FW1]
                                     | pressed[fdci_pkg::BTN_REV1];
        req.moves[fdci_pkg::CL_BLK2] = all_blocks | pressed[fdci_pkg::BTN_FW2]
                                     | pressed[fdci_pkg::BTN_REV2];
        req.moves[fdci_pkg::CL_BLK3] = all_blocks | pressed[fdci_pkg::BTN_FW3]
                                     | pressed[fdci_pkg::BTN_REV3];
        req.fw  = |(pressed & FW_LANES);
        req.rev = |(pressed & REV_LANES);
        return req;
    endfunction

    function automatic tick_result_t advance_interlock(
        input logic [fdci_pkg::BTN_W-1:0] buttons_n,
        input logic [fdci_pkg::FB_W-1:0]  feedback,
        input logic                       inhibit,
        input logic                       kill_ok);
        request_t req;
        req = decode_request(buttons_n);
        if (!kill_ok) begin
            pred_clutch  = '0;
            pred_reverse = 1'b0;
            pred_enable  = 1'b0;
            pred_mode    = fdci_pkg::CODE_HALT;
        end else begin
            case (pred_mode)
                fdci_pkg::CODE_IDLE:
                begin
                    if (req.fw ^ req.rev) begin
                        // Blocks that stay put keep their clutch forced.
                        pred_clutch                    = '0;
                        pred_clutch[fdci_pkg::CL_MAIN] = 1'b1;
                        pred_clutch[fdci_pkg::CL_BLK1] = !req.moves[fdci_pkg::CL_BLK1];
                        pred_clutch[fdci_pkg::CL_BLK2] = !req.moves[fdci_pkg::CL_BLK2];
                        pred_clutch[fdci_pkg::CL_BLK3] = !req.moves[fdci_pkg::CL_BLK3];
                        pred_reverse                   = req.rev;
                        pred_mode                      = fdci_pkg::CODE_PREPARE;
                    end
                end
                fdci_pkg::CODE_PREPARE:
                begin
                    if (buttons_n == NO_BUTTONS) begin
                        pred_reverse = 1'b0;
                        pred_clutch  = '0;
                        pred_mode    = fdci_pkg::CODE_IDLE;
                    end else if (!inhibit && feedback == req.moves) begin
                        pred_enable = 1'b1;
                        pred_mode   = fdci_pkg::CODE_MOVING;
                    end
                end
                fdci_pkg::CODE_MOVING:
                begin
                    if (buttons_n == NO_BUTTONS || (!pred_reverse && req.rev)) begin
                        pred_reverse = 1'b0;
                        pred_enable  = 1'b0;
                        pred_mode    = fdci_pkg::CODE_PREPARE;
                    end
                end
                default:
                begin
                    pred_clutch  = '0;
                    pred_reverse = 1'b0;
                    pred_enable  = 1'b0;
                    pred_mode    = fdci_pkg::CODE_IDLE;
                end
            endcase
        end
        return '{clutch: pred_clutch, reverse: pred_reverse, enable: pred_enable,
                 mode: pred_mode};
    endfunction

    task automatic log_failure(input string why, input tick_result_t want,
                               input tick_result_t got);
        mismatches++;
        if (mismatches <= SHOWN_ERRORS)
            $display({"%s at %0t: expected clutch=%h reverse=%b enable=%b mode=%0d,",
                      " got clutch=%h reverse=%b enable=%b mode=%0d"},
                     why, $time, want.clutch, want.reverse, want.enable, want.mode,
                     got.clutch, got.reverse, got.enable, got.mode);
    endtask

    // Results are checked before the word accepted on the same edge is predicted.
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) begin
                seen_word = '{clutch: clutch_force, reverse: motor_reverse,
                              enable: motor_enable, mode: mode_now};
                if (pending.size() == 0) begin
                    log_failure("unexpected word", 'x, seen_word);
                end else begin
                    next_word = pending.pop_front();
                    if (seen_word !== next_word)
                        log_failure("mismatch", next_word, seen_word);
                end
            end
            if (in_valid && in_ready) begin
                next_word = advance_interlock(move_buttons_n, feedback_switches,
                                              start_inhibit, kill_released);
                pending.push_back(row_typed ? row_want : next_word);
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [fdci_pkg::BTN_W-1:0] pick_lanes(
        input logic [fdci_pkg::BTN_W-1:0] lanes);
        logic [fdci_pkg::BTN_W-1:0] pressed;
        do
            pressed = 8'($urandom) & lanes;
        while (pressed == '0);
        return pressed;
    endfunction

    function automatic logic [fdci_pkg::FB_W-1:0] pick_feedback(input logic [2:0] moves);
        if ($urandom_range(0, 4) != 0)
            return moves;
        return 3'($urandom);
    endfunction

    function automatic logic draw_kill_line();
        return $urandom_range(0, 59) != 0;
    endfunction

    task automatic send_tick(input logic [fdci_pkg::BTN_W-1:0] buttons_n,
                             input logic [fdci_pkg::FB_W-1:0] feedback,
                             input logic inhibit, input logic kill_ok,
                             input logic typed = PREDICTED, input tick_result_t want = '0);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid          <= 1'b1;
        move_buttons_n    <= buttons_n;
        feedback_switches <= feedback;
        start_inhibit     <= inhibit;
        kill_released     <= kill_ok;
        row_typed         <= typed;
        row_want          <= want;
        do
            @(posedge clk);
        while (!in_ready);
        sent++;
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending.size() != 0)
            @(posedge clk);
    endtask

    // One operator move: press, maybe turn around, then let go.
    task automatic run_move();
        logic [fdci_pkg::BTN_W-1:0] hold_n;
        request_t                   req;
        hold_n = ~pick_lanes($urandom_range(0, 2) == 0 ? REV_LANES : FW_LANES);
        req = decode_request(hold_n);
        repeat ($urandom_range(1, 8))
            send_tick(hold_n, pick_feedback(req.moves), $urandom_range(0, 6) == 0,
                      draw_kill_line());
        if ($urandom_range(0, 2) == 0) begin
            hold_n = ~(pick_lanes(REV_LANES) |
                       ($urandom_range(0, 1) == 0 ? pick_lanes(FW_LANES) : '0));
            req = decode_request(hold_n);
            repeat ($urandom_range(1, 6))
                send_tick(hold_n, pick_feedback(req.moves), $urandom_range(0, 6) == 0,
                          draw_kill_line());
        end
        repeat ($urandom_range(1, 3))
            send_tick(NO_BUTTONS, 3'($urandom), 1'($urandom), draw_kill_line());
    endtask

    initial begin : sink
        int unsigned gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever begin
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
            gap = pick_gap();
            if (gap != 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    initial begin : source
        int unsigned next_drain;
        rst_n             = 1'b0;
        in_valid          = 1'b0;
        move_buttons_n    = NO_BUTTONS;
        feedback_switches = '0;
        start_inhibit     = 1'b0;
        kill_released     = 1'b1;
        row_typed         = PREDICTED;
        row_want          = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < SCRIPT_LEN; i++)
            send_tick(SCRIPT[i].buttons_n, SCRIPT[i].feedback, SCRIPT[i].inhibit,
                      SCRIPT[i].kill_ok, SCRIPT[i].typed, SCRIPT[i].want);
        wait_for_results();

        next_drain = sent + DRAIN_EVERY;
        while (sent < SCRIPT_LEN + RANDOM_TICKS) begin
            if (sent >= next_drain) begin
                wait_for_results();
                next_drain = sent + DRAIN_EVERY;
            end
            if ($urandom_range(0, 24) == 0)
                calm = !calm;
            if ($urandom_range(0, 9) == 0)
                send_tick(8'($urandom), 3'($urandom), 1'($urandom),
                          $urandom_range(0, 7) != 0);
            else
                run_move();
        end

        wait_for_results();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/fdci_pkg.sv
hw/rtl/fdci_step.sv
hw/rtl/film_drive_clutch_interlock.sv
tb/film_drive_clutch_interlock_test.sv
